[rtl/rgbyuv_pkg.sv]
// shared types and constants for the rgb to yuv 4:2:0 converter
package rgbyuv_pkg;

    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned DIM_W      = 14;
    localparam int unsigned SUM_W      = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_GRAY_INPUT   = 2'd2
    } cfg_reg_t;

    // bt.601 integer weights, negative terms kept as magnitudes
    localparam logic [SUM_W-1:0] K_Y_R = 17'd66;
    localparam logic [SUM_W-1:0] K_Y_G = 17'd129;
    localparam logic [SUM_W-1:0] K_Y_B = 17'd25;
    localparam logic [SUM_W-1:0] K_U_R = 17'd38;
    localparam logic [SUM_W-1:0] K_U_G = 17'd74;
    localparam logic [SUM_W-1:0] K_U_B = 17'd112;
    localparam logic [SUM_W-1:0] K_V_R = 17'd112;
    localparam logic [SUM_W-1:0] K_V_G = 17'd94;
    localparam logic [SUM_W-1:0] K_V_B = 17'd18;

    // offsets already scaled by 256
    localparam logic [SUM_W-1:0] Y_BIAS = 17'd4096;
    localparam logic [SUM_W-1:0] C_BIAS = 17'd32768;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       chroma_valid;
        logic       frame_end;
    } pix_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
    } yuv_t;

endpackage

[rtl/rgbyuv_math.sv]
// color matrix: one registered pixel to luma and chroma
module rgbyuv_math
    import rgbyuv_pkg::*;
(
    input  pix_t pix,
    output yuv_t yuv
);

    logic [SUM_W-1:0] r_ext;
    logic [SUM_W-1:0] g_ext;
    logic [SUM_W-1:0] b_ext;
    logic [SUM_W-1:0] y_sum;
    logic [SUM_W-1:0] u_sum;
    logic [SUM_W-1:0] v_sum;

    assign r_ext = {9'd0, pix.red};
    assign g_ext = {9'd0, pix.green};
    assign b_ext = {9'd0, pix.blue};

    // biased sums never go negative nor reach 2^16
    assign y_sum = K_Y_R * r_ext + K_Y_G * g_ext + K_Y_B * b_ext + Y_BIAS;
    assign u_sum = K_U_B * b_ext + C_BIAS - K_U_R * r_ext - K_U_G * g_ext;
    assign v_sum = K_V_R * r_ext + C_BIAS - K_V_G * g_ext - K_V_B * b_ext;

    always_comb
    begin
        yuv.luma     = y_sum[15:8];
        yuv.chroma_u = pix.chroma_valid ? u_sum[15:8] : 8'd0;
        yuv.chroma_v = pix.chroma_valid ? v_sum[15:8] : 8'd0;
    end

endmodule

[rtl/rgb_to_yuv420_converter.sv]
// top level of the streaming rgb to yuv 4:2:0 converter
//
// input stream s_axis carries one pixel per transfer in raster order;
// output stream m_axis carries one result per pixel: luma always, chroma
// u and v only on even lines at even columns (flagged in tuser, zero
// otherwise), tlast on the last pixel of the frame.
// the pixel is registered on input, the color matrix runs between that
// register and the output register: output valid rises once the pixel
// leaves the input register; throughput is one pixel per cycle while
// m_axis_tready is high, set by the single constant-multiply stage.
// frame size and gray mode are written through the cfg port; the user
// writes them while the stream is idle (not enforced by the block).
// writes never clear the column and line counters. reset empties both
// stages, zeroes the counters and loads 640 x 480, color mode.
// when m_axis_tready is low the output register holds, the input
// register fills, and then s_axis_tready drops; no transfer is lost.
module rgb_to_yuv420_converter
    import rgbyuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // red, green, blue
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // luma, chroma_u, chroma_v
    output logic                  m_axis_tuser,  // chroma_valid
    output logic                  m_axis_tlast   // frame_end
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int LIN_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [DIM_W-1:0] W_CAP = DIM_W'(MAX_WIDTH) & ~DIM_W'(1);
    localparam logic [DIM_W-1:0] H_CAP = DIM_W'(MAX_HEIGHT);

    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic                  gray_input_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [LIN_W-1:0] line_reg;
    logic [LIN_W-1:0] line_next;

    logic s1_valid_reg;
    pix_t s1_reg;
    pix_t s1_next;
    logic out_valid_reg;
    yuv_t out_reg;
    yuv_t yuv;
    logic out_user_reg;
    logic out_last_reg;

    logic [DIM_W-1:0] w_raw;
    logic [DIM_W-1:0] h_raw;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic             last_col;
    logic             last_line;
    logic             in_xfer;
    logic             s1_adv;

    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // effective frame size
    always_comb
    begin
        w_raw = {1'b0, frame_width_reg[CFG_DATA_W-1:1], 1'b0};
        h_raw = {1'b0, frame_height_reg};
        if (w_raw < DIM_W'(2))
            eff_w = DIM_W'(2);
        else if (w_raw > W_CAP)
            eff_w = W_CAP;
        else
            eff_w = w_raw;
        if (h_raw < DIM_W'(1))
            eff_h = DIM_W'(1);
        else if (h_raw > H_CAP)
            eff_h = H_CAP;
        else
            eff_h = h_raw;
    end

    always_comb
    begin
        last_col  = (DIM_W'(col_reg) + DIM_W'(1)) >= eff_w;
        last_line = (DIM_W'(line_reg) + DIM_W'(1)) >= eff_h;
        if (last_col)
        begin
            col_next  = '0;
            line_next = last_line ? '0 : line_reg + LIN_W'(1);
        end
        else
        begin
            col_next  = col_reg + COL_W'(1);
            line_next = line_reg;
        end
        s1_next.red          = s_axis_tdata[7:0];
        s1_next.green        = gray_input_reg ? s_axis_tdata[7:0] : s_axis_tdata[15:8];
        s1_next.blue         = gray_input_reg ? s_axis_tdata[7:0] : s_axis_tdata[23:16];
        s1_next.chroma_valid = !line_reg[0] && !col_reg[0];
        s1_next.frame_end    = last_col && last_line;
    end

    rgbyuv_math u_math
    (
        .pix (s1_reg),
        .yuv (yuv)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_DATA_W'(640);
            frame_height_reg <= CFG_DATA_W'(480);
            gray_input_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_GRAY_INPUT:   gray_input_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // counters and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            line_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                col_reg  <= col_next;
                line_reg <= line_next;
            end
            if (s_axis_tready)
                s1_valid_reg <= s_axis_tvalid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_reg <= s1_next;
        if (s1_adv && s1_valid_reg)
        begin
            out_reg      <= yuv;
            out_user_reg <= s1_reg.chroma_valid;
            out_last_reg <= s1_reg.frame_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.chroma_v, out_reg.chroma_u, out_reg.luma};
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
